>>> sv/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg: shared types and constants for the RGB to HSL converter
// Holds the divider lane layout, the pipeline word and the fixed widths.
// ----------------------------------------------------------------------------
package rth_pkg;

  // Fraction bits of the hue, saturation and lightness results.
  localparam int FRAC_W = 16;

  // Dividend width: every dividend stays below 2**28.
  localparam int X_W = 28;

  // Quotient bits produced by the long division.
  localparam int Q_W = 18;

  // Divisor and partial remainder width: divisors reach 12 * 255 = 3060.
  localparam int DIV_W = 12;
  localparam int REM_W = 12;

  // Quotient bits resolved in each divider stage, and the stage count.
  localparam int STEPS_PER_STAGE = 3;
  localparam int NUM_DIV_STAGES = Q_W / STEPS_PER_STAGE;

  // Divider lanes.
  localparam int NUM_LANES = 3;
  localparam int LANE_SAT = 0;
  localparam int LANE_HUE = 1;
  localparam int LANE_LIGHT = 2;

  // Lightness divisor: round(sum * 65536 / 510) = floor((2 * sum * 65536 + 510) / 1020).
  localparam logic [DIV_W-1:0] LIGHT_DIV = 12'd1020;
  localparam logic [X_W-1:0] LIGHT_BIAS = 28'd510;

  // One lane of the long division: partial remainder, a shift register that
  // holds the dividend bits still to be consumed with quotient bits behind
  // them, and the divisor.
  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [Q_W-1:0]   acc;
    logic [DIV_W-1:0] divisor;
  } lane_t;

  // Word that travels down the pipeline with each pixel.
  typedef struct packed {
    lane_t [NUM_LANES-1:0] lane;
    logic                  grey;
  } work_t;

endpackage

>>> sv/rth_prep.sv
// ----------------------------------------------------------------------------
// rth_prep: first pipeline stage of the RGB to HSL converter
// Finds max and min, and forms the dividends and divisors of the three lanes.
// ----------------------------------------------------------------------------
module rth_prep (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [7:0]     red,
  input  logic [7:0]     green,
  input  logic [7:0]     blue,
  input  logic           down_ready,
  output logic           in_ready,
  output logic           out_valid,
  output rth_pkg::work_t out_work
);

  localparam int XW = rth_pkg::X_W;
  localparam int QW = rth_pkg::Q_W;
  localparam int DW = rth_pkg::DIV_W;
  localparam int RW = rth_pkg::REM_W;
  localparam int SH = rth_pkg::FRAC_W + 1;

  logic           red_max;
  logic           green_max;
  logic [7:0]     mx;
  logic [7:0]     mn;
  logic [8:0]     sum;
  logic [7:0]     delta;
  logic [7:0]     den;
  logic [10:0]    delta6;
  logic [10:0]    hnum;
  logic [XW-1:0]  x_sat;
  logic [XW-1:0]  x_hue;
  logic [XW-1:0]  x_light;
  logic [DW-1:0]  d_sat;
  logic [DW-1:0]  d_hue;
  rth_pkg::work_t work_next;

  // Load a lane: the top dividend bits seed the remainder.
  function automatic rth_pkg::lane_t make_lane(input logic [XW-1:0] x,
                                               input logic [DW-1:0] d);
    rth_pkg::lane_t l;
    l.rem     = RW'(x[XW-1:QW]);
    l.acc     = x[QW-1:0];
    l.divisor = d;
    return l;
  endfunction

  // Largest and smallest channel; ties go to red, then green.
  always_comb begin
    red_max   = (red >= green) && (red >= blue);
    green_max = !red_max && (green >= blue);
    if (red_max) begin
      mx = red;
    end else if (green_max) begin
      mx = green;
    end else begin
      mx = blue;
    end
    if ((red <= green) && (red <= blue)) begin
      mn = red;
    end else if (green <= blue) begin
      mn = green;
    end else begin
      mn = blue;
    end
    sum   = {1'b0, mx} + {1'b0, mn};
    delta = mx - mn;
  end

  // Saturation divisor and hue numerator (sector * delta + difference).
  always_comb begin
    den    = (sum < 9'd255) ? sum[7:0] : 8'(9'd510 - sum);
    delta6 = (11'(delta) << 2) + (11'(delta) << 1);
    if (red_max) begin
      if (green < blue) begin
        hnum = delta6 - 11'(blue - green);
      end else begin
        hnum = 11'(green - blue);
      end
    end else if (green_max) begin
      hnum = (11'(delta) << 1) + 11'(blue) - 11'(red);
    end else begin
      hnum = (11'(delta) << 2) + 11'(red) - 11'(green);
    end
  end

  // Dividends and divisors for round-half-up division: (2n + d) / (2d).
  always_comb begin
    x_sat   = (XW'(delta) << SH) | XW'(den);
    d_sat   = DW'({den, 1'b0});
    x_hue   = (XW'(hnum) << SH) + XW'(delta6);
    d_hue   = (DW'(delta) << 3) + (DW'(delta) << 2);
    x_light = (XW'(sum) << SH) + rth_pkg::LIGHT_BIAS;
    work_next.lane[rth_pkg::LANE_SAT]   = make_lane(x_sat, d_sat);
    work_next.lane[rth_pkg::LANE_HUE]   = make_lane(x_hue, d_hue);
    work_next.lane[rth_pkg::LANE_LIGHT] = make_lane(x_light, rth_pkg::LIGHT_DIV);
    work_next.grey = (delta == 8'd0);
  end

  // Stage register; it takes a new transaction when empty or when drained.
  assign in_ready = !out_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

>>> sv/rth_div_stage.sv
// ----------------------------------------------------------------------------
// rth_div_stage: one stage of the pipelined long divider
// Resolves a few quotient bits of each lane by restoring division steps.
// ----------------------------------------------------------------------------
module rth_div_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  rth_pkg::work_t in_work,
  input  logic           down_ready,
  output logic           in_ready,
  output logic           out_valid,
  output rth_pkg::work_t out_work
);

  localparam int QW = rth_pkg::Q_W;
  localparam int RW = rth_pkg::REM_W;

  rth_pkg::work_t work_next;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  function automatic rth_pkg::lane_t div_step(input rth_pkg::lane_t cur);
    rth_pkg::lane_t nxt;
    logic [RW:0]    trial;
    logic [RW:0]    diff;
    logic           qbit;
    nxt   = cur;
    trial = {cur.rem, cur.acc[QW-1]};
    diff  = trial - (RW + 1)'(cur.divisor);
    qbit  = (trial >= (RW + 1)'(cur.divisor));
    nxt.rem = qbit ? diff[RW-1:0] : trial[RW-1:0];
    nxt.acc = {cur.acc[QW-2:0], qbit};
    return nxt;
  endfunction

  // Lanes are independent; the steps within a lane are chained.
  always_comb begin
    work_next = in_work;
    for (int l = 0; l < rth_pkg::NUM_LANES; l++) begin
      for (int s = 0; s < rth_pkg::STEPS_PER_STAGE; s++) begin
        work_next.lane[l] = div_step(work_next.lane[l]);
      end
    end
  end

  // Stage register with pass-through ready.
  assign in_ready = !out_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_work <= work_next;
    end
  end

endmodule

>>> sv/rgb_to_hsl_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsl_core: pipelined 8-bit RGB to fixed-point HSL converter
// Lightness and saturation are unsigned Q1.16, hue is a Q0.16 fraction of a
// turn; all three are rounded to nearest with halves rounded up.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pixel: red, green, blue.
//   Output channel (out_valid / out_stall) carries hue, saturation, lightness.
//   A transaction happens at a rising edge where valid is high and stall low.
//   One stage finds max, min and the dividends, then six divider stages each
//   resolve three quotient bits of three parallel long divisions. Throughput
//   is one pixel per clock while the receiver does not stall, and every stage
//   holds its own pixel.
//   When the receiver stalls, the pipeline keeps filling until each stage
//   holds a pixel, then in_stall rises; nothing is dropped or repeated.
//   in_stall is driven combinationally from out_stall and stage occupancy.
//   A grey pixel (max equal to min) gives zero hue and saturation.
//   Synchronous reset empties the pipeline; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rgb_to_hsl_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] hue,
  output logic [16:0] saturation,
  output logic [16:0] lightness
);

  localparam int NS = rth_pkg::NUM_DIV_STAGES;

  rth_pkg::work_t stage_work  [0:NS];
  logic           stage_valid [0:NS];
  logic           stage_ready [0:NS];
  logic           prep_in_ready;
  rth_pkg::lane_t hue_lane;
  rth_pkg::lane_t sat_lane;
  rth_pkg::lane_t light_lane;

  // First stage: channel compare and dividend setup.
  rth_prep u_prep (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .down_ready (stage_ready[0]),
    .in_ready   (prep_in_ready),
    .out_valid  (stage_valid[0]),
    .out_work   (stage_work[0])
  );

  // Divider stages; the last one is the output register.
  for (genvar k = 0; k < NS; k++) begin : g_div
    rth_div_stage u_stage (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (stage_valid[k]),
      .in_work    (stage_work[k]),
      .down_ready (stage_ready[k+1]),
      .in_ready   (stage_ready[k]),
      .out_valid  (stage_valid[k+1]),
      .out_work   (stage_work[k+1])
    );
  end

  assign stage_ready[NS] = !out_stall;
  assign in_stall        = !prep_in_ready;

  // Results from the final quotients; a grey pixel forces hue and saturation to zero.
  assign hue_lane   = stage_work[NS].lane[rth_pkg::LANE_HUE];
  assign sat_lane   = stage_work[NS].lane[rth_pkg::LANE_SAT];
  assign light_lane = stage_work[NS].lane[rth_pkg::LANE_LIGHT];

  assign out_valid  = stage_valid[NS];
  assign hue        = stage_work[NS].grey ? 16'd0 : hue_lane.acc[15:0];
  assign saturation = stage_work[NS].grey ? 17'd0 : sat_lane.acc[16:0];
  assign lightness  = light_lane.acc[16:0];

  // Lightness never exceeds 1.0.
  a_light_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (light_lane.acc <= 18'h10000))
    else $error("lightness quotient above 1.0");

  // Saturation never exceeds 1.0.
  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !stage_work[NS].grey) |-> (sat_lane.acc <= 18'h10000))
    else $error("saturation quotient above 1.0");

  // Hue stays below one full turn, so no quotient bits are cut off.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !stage_work[NS].grey) |-> (hue_lane.acc[17:16] == 2'b00))
    else $error("hue quotient overflows 16 bits");

  // Zero saturation only occurs for grey pixels, which carry zero hue.
  a_grey_hue: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (saturation == 17'd0)) |-> (hue == 16'd0))
    else $error("nonzero hue with zero saturation");

endmodule

>>> verif/tb_rgb_to_hsl_core.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsl_core: self-checking bench for the RGB to HSL converter
// Pixels go in through the valid/stall input channel, and each converted
// result is checked field by field against an exact rational model that
// rounds half up. Directed corner pixels come first, then random pixels that
// favor grey pixels, ties, the saturation boundary and small deltas. Both
// sides idle at random, and the receiver holds off long enough to back up
// the pipeline.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsl_core;

  typedef struct {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] hue;
    logic [16:0] saturation;
    logic [16:0] lightness;
  } hsl_pixel_t;

  // Keeps the expected conversion of every accepted pixel in arrival order.
  class hsl_scoreboard;
    hsl_pixel_t expected_hsl_q[$];
    int         mismatches;

    function int unsigned round_half_up(int unsigned num, int unsigned den);
      return (2 * num + den) / (2 * den);
    endfunction

    // Exact conversion of one pixel.
    function hsl_pixel_t pixel_to_hsl(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      hsl_pixel_t  p;
      int unsigned ri, gi, bi, mx, mn, sum, delta, den, turn, one;
      ri = 32'(r);
      gi = 32'(g);
      bi = 32'(b);
      one = 1 << rth_pkg::FRAC_W;
      mx = (ri > gi) ? ri : gi;
      if (bi > mx) mx = bi;
      mn = (ri < gi) ? ri : gi;
      if (bi < mn) mn = bi;
      sum = mx + mn;
      delta = mx - mn;
      p.red = r;
      p.green = g;
      p.blue = b;
      p.lightness = 17'(round_half_up(sum * one, 510));
      p.hue = '0;
      p.saturation = '0;
      if (delta != 0) begin
        den = (sum < 255) ? sum : (510 - sum);
        p.saturation = 17'(round_half_up(delta * one, den));
        // Sector offset times delta plus the channel difference; ties go to
        // red first, then green.
        if (mx == ri) begin
          if (gi < bi) turn = 6 * delta - (bi - gi);
          else turn = gi - bi;
        end else if (mx == gi) begin
          turn = 2 * delta + bi - ri;
        end else begin
          turn = 4 * delta + ri - gi;
        end
        p.hue = 16'(round_half_up(turn * one, 6 * delta));
      end
      return p;
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      expected_hsl_q.push_back(pixel_to_hsl(r, g, b));
    endfunction

    // Counts a mismatch and tells whether it should still be reported.
    function bit count_mismatch();
      mismatches++;
      return mismatches <= 10;
    endfunction

    function void check_result(logic [15:0] h, logic [16:0] s, logic [16:0] l);
      hsl_pixel_t p;
      if (expected_hsl_q.size() == 0) begin
        if (count_mismatch())
          $display("unexpected result: hue %0d sat %0d light %0d", h, s, l);
        return;
      end
      p = expected_hsl_q.pop_front();
      if (h !== p.hue || s !== p.saturation || l !== p.lightness) begin
        if (count_mismatch())
          $display("rgb (%0d,%0d,%0d): expected hue %0d sat %0d light %0d, got %0d %0d %0d",
                   p.red, p.green, p.blue, p.hue, p.saturation, p.lightness, h, s, l);
      end
    endfunction

    function int pending();
      return expected_hsl_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] hue;
  logic [16:0] saturation;
  logic [16:0] lightness;

  hsl_scoreboard hsl_sb;
  int            send_idle_pct;
  int            recv_stall_pct;
  bit            hold_request;
  int            hold_left;

  rgb_to_hsl_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: random stall, or a long counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 299;
      out_stall = 1'b1;
    end else begin
      out_stall = ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: check the delivered result first, then note the accepted pixel.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) hsl_sb.check_result(hue, saturation, lightness);
      if (in_valid && !in_stall) hsl_sb.note_pixel(red, green, blue);
    end
  end

  // Offers one pixel, starting and ending on a falling edge.
  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    red = r;
    green = g;
    blue = b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Sends three channel values in a random channel order.
  task automatic send_shuffled(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    case ($urandom_range(5))
      0: send_pixel(a, b, c);
      1: send_pixel(a, c, b);
      2: send_pixel(b, a, c);
      3: send_pixel(b, c, a);
      4: send_pixel(c, a, b);
      default: send_pixel(c, b, a);
    endcase
  endtask

  function automatic logic [7:0] corner_level();
    case ($urandom_range(5))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      default: return 8'd255;
    endcase
  endfunction

  // One random pixel, weighted toward the interesting regions.
  task automatic send_random_pixel();
    int         kind;
    int         total;
    logic [7:0] hi, mid, lo;
    kind = $urandom_range(99);
    if (kind < 40) begin
      send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    end else if (kind < 50) begin
      mid = 8'($urandom_range(255));
      send_pixel(mid, mid, mid);
    end else if (kind < 65) begin
      // Two channels tie, either for the largest or for the smallest.
      hi = 8'($urandom_range(1, 255));
      lo = 8'($urandom_range(0, hi - 1));
      if ($urandom_range(1)) send_shuffled(hi, hi, lo);
      else send_shuffled(hi, lo, lo);
    end else if (kind < 80) begin
      // max + min close to 255, where the saturation divisor switches.
      total = $urandom_range(250, 260);
      hi = 8'($urandom_range((total + 1) / 2, (total > 255) ? 255 : total));
      lo = 8'(total - int'(hi));
      mid = 8'($urandom_range(lo, hi));
      send_shuffled(hi, mid, lo);
    end else if (kind < 90) begin
      send_pixel(corner_level(), corner_level(), corner_level());
    end else begin
      lo = 8'($urandom_range(0, 253));
      hi = lo + 8'($urandom_range(1, 2));
      mid = 8'($urandom_range(lo, hi));
      send_shuffled(hi, mid, lo);
    end
  endtask

  initial begin
    int guard;
    hsl_sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    out_stall = 1'b0;
    red = '0;
    green = '0;
    blue = '0;
    hold_request = 1'b0;
    hold_left = 0;
    send_idle_pct = 20;
    recv_stall_pct = 83;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed corners: black, white, grey, primaries, every tie, red with
    // green below blue, full saturation and both sides of the 255 boundary.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd254, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd1, 8'd0);
    send_pixel(8'd200, 8'd100, 8'd50);
    send_pixel(8'd50, 8'd200, 8'd100);
    send_pixel(8'd100, 8'd50, 8'd200);
    send_pixel(8'd254, 8'd0, 8'd0);
    send_pixel(8'd128, 8'd127, 8'd127);
    send_pixel(8'd127, 8'd126, 8'd126);
    send_pixel(8'd200, 8'd56, 8'd56);
    send_pixel(8'd255, 8'd254, 8'd254);

    // Sender idles lightly while the receiver stalls heavily.
    repeat (600) send_random_pixel();

    // The other way round.
    send_idle_pct = 83;
    recv_stall_pct = 20;
    repeat (600) send_random_pixel();

    // Back-to-back traffic behind a long receiver hold-off, then no idling.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_request = 1'b1;
    repeat (600) send_random_pixel();
    in_valid = 1'b0;

    guard = 0;
    while (hsl_sb.pending() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);

    if (hsl_sb.pending() != 0)
      $display("%0d expected results never arrived", hsl_sb.pending());
    if (hsl_sb.mismatches == 0 && hsl_sb.pending() == 0) begin
      $display("tb_rgb_to_hsl_core OK");
    end else begin
      $display("tb_rgb_to_hsl_core NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #4000000;
    $display("tb_rgb_to_hsl_core NOT OK");
    $finish;
  end

endmodule
